### hdl/ipv4_address_learning_table_core_defines.svh
// Assertion macros for the IPv4 address learning table core.
`ifndef IPV4_ADDRESS_LEARNING_TABLE_CORE_DEFINES_SVH
`define IPV4_ADDRESS_LEARNING_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define IALT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ialt assertion failed");
`define IALT_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ialt forbidden condition seen");
`else
`define IALT_ASSERT(label, clk, rst, prop)
`define IALT_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

### hdl/ialt_pkg.sv
// Types and constants shared by the IPv4 address learning table core.
package ialt_pkg;

   localparam int TABLE_DEPTH     = 32;
   localparam int ADDR_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
   localparam int TOTAL_W         = 10;
   localparam int BYTES_PER_ENTRY = 12;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   typedef enum logic {
      OP_OBSERVE = 1'b0,
      OP_DUMP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_ENTRY = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CMD_LEARN = 1'b0,
      CMD_DUMP  = 1'b1
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DUMP_HEAD,
      ST_DUMP_READ,
      ST_DUMP_WAIT
   } eng_state_type;

   typedef struct packed {
      op_type      operation;
      logic        header_complete;
      logic [15:0] ether_type;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [15:0] buffer_bytes;
   } req_payload_type;

   typedef struct packed {
      status_type          status;
      logic [31:0]         entry_ip;
      logic [47:0]         entry_mac;
      logic [TOTAL_W-1:0]  total_bytes;
      logic                last;
   } rsp_payload_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  dst_ip;
      logic [31:0]  src_ip;
      logic [47:0]  mac;
      logic [15:0]  buffer_bytes;
   } cmd_type;

endpackage

### hdl/ialt_intf.sv
// Valid/ready channel interfaces for requests, internal commands and results.
interface ialt_req_if import ialt_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ialt_cmd_if import ialt_pkg::*; ();
   logic    valid;
   logic    ready;
   cmd_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ialt_rsp_if import ialt_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hdl/ialt_front.sv
// Request classifier: turns dumps and complete IPv4 headers into commands, drops the rest.
module ialt_front import ialt_pkg::*; (
   ialt_req_if.sink    req,
   ialt_cmd_if.source  cmd
);

   logic is_dump;
   logic is_ipv4;

   assign is_dump = (req.payload.operation == OP_DUMP);
   assign is_ipv4 = req.payload.header_complete &&
                    (req.payload.ether_type == ETHERTYPE_IPV4);

   assign cmd.valid                = req.valid && (is_dump || is_ipv4);
   assign cmd.payload.kind         = is_dump ? CMD_DUMP : CMD_LEARN;
   assign cmd.payload.dst_ip       = req.payload.dst_ip;
   assign cmd.payload.src_ip       = req.payload.src_ip;
   assign cmd.payload.mac          = req.payload.src_mac;
   assign cmd.payload.buffer_bytes = req.payload.buffer_bytes;

   // dropped requests are taken whenever the queue could take a command
   assign req.ready = cmd.ready;

endmodule

### hdl/ialt_cmd_queue.sv
// Small command FIFO between the classifier and the table engine.
module ialt_cmd_queue import ialt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ialt_cmd_if.sink    push,
   ialt_cmd_if.source  pop
);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign push.ready  = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign pop.valid   = (fill_ff != '0);
   assign pop.payload = entries_ff[rd_ptr_ff];

   assign do_push = push.valid && push.ready;
   assign do_pop  = pop.valid && pop.ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.payload;
      end
   end

endmodule

### hdl/ialt_engine.sv
// Table engine: sequential IP lookup, insertion and table dump with a result register.
`include "ipv4_address_learning_table_core_defines.svh"

module ialt_engine import ialt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ialt_cmd_if.sink    cmd,
   ialt_rsp_if.source  rsp
);

   // entries in insertion order: newest at count - 1
   logic [31:0]         ip_mem_ff  [TABLE_DEPTH];
   logic [47:0]         mac_mem_ff [TABLE_DEPTH];

   eng_state_type       state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic                phase_ff, phase_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]   dump_idx_ff, dump_idx_in;
   logic [31:0]         rd_ip_ff;
   logic [47:0]         rd_mac_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic                load;
   logic [31:0]         cur_ip;
   logic                hit;
   logic                scan_more;
   logic                scan_done;
   logic                offer_end;
   logic                out_free;
   logic [TOTAL_W-1:0]  total;
   logic                dump_short;
   logic                dump_empty;
   logic                pop;

   assign cmd.ready   = (state_ff == ST_IDLE);
   assign pop         = cmd.valid && cmd.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   assign cur_ip     = phase_ff ? cmd_ff.src_ip : cmd_ff.dst_ip;
   assign hit        = cmp_vld_ff && (rd_ip_ff == cur_ip);
   assign scan_more  = (scan_idx_ff < count_ff);
   assign scan_done  = !hit && !scan_more && !cmp_vld_ff;
   assign offer_end  = hit || scan_done;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign total      = TOTAL_W'(count_ff) * TOTAL_W'(BYTES_PER_ENTRY);
   assign dump_short = (cmd_ff.buffer_bytes < 16'(total));
   assign dump_empty = (count_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = (cmd.payload.kind == CMD_DUMP) ? ST_DUMP_HEAD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (offer_end && phase_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_HEAD: begin
            if (dump_short || dump_empty) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_DUMP_READ;
            end
         end
         ST_DUMP_READ: begin
            state_in = ST_DUMP_WAIT;
         end
         ST_DUMP_WAIT: begin
            if (out_free) begin
               state_in = (dump_idx_ff == '0) ? ST_IDLE : ST_DUMP_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in      = cmd_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = 1'b0;
      dump_idx_in = dump_idx_ff;
      rd_en       = 1'b0;
      rd_addr     = scan_idx_ff[ADDR_W-1:0];
      wr_en       = 1'b0;
      load        = 1'b0;
      rsp_in      = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in      = cmd.payload;
               phase_in    = 1'b0;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               cmp_vld_in = 1'b0;
            end else if (scan_more) begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff[ADDR_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
               cmp_vld_in  = 1'b1;
            end else if (!cmp_vld_ff) begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            if (offer_end) begin
               phase_in    = 1'b1;
               scan_idx_in = '0;
            end
         end
         ST_DUMP_HEAD: begin
            rsp_in.status      = dump_short ? STATUS_SHORT : STATUS_EMPTY;
            rsp_in.entry_ip    = '0;
            rsp_in.entry_mac   = '0;
            rsp_in.total_bytes = total;
            rsp_in.last        = 1'b1;
            if (dump_short || dump_empty) begin
               load = out_free;
            end else begin
               dump_idx_in = ADDR_W'(count_ff - 1'b1);
            end
         end
         ST_DUMP_READ: begin
            rd_en   = 1'b1;
            rd_addr = dump_idx_ff;
         end
         ST_DUMP_WAIT: begin
            rsp_in.status      = STATUS_ENTRY;
            rsp_in.entry_ip    = rd_ip_ff;
            rsp_in.entry_mac   = rd_mac_ff;
            rsp_in.total_bytes = total;
            rsp_in.last        = (dump_idx_ff == '0);
            if (out_free) begin
               load        = 1'b1;
               dump_idx_in = dump_idx_ff - 1'b1;
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      phase_ff    <= phase_in;
      scan_idx_ff <= scan_idx_in;
      dump_idx_ff <= dump_idx_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem_ff[count_ff[ADDR_W-1:0]]  <= cur_ip;
         mac_mem_ff[count_ff[ADDR_W-1:0]] <= cmd_ff.mac;
      end
      if (rd_en) begin
         rd_ip_ff  <= ip_mem_ff[rd_addr];
         rd_mac_ff <= mac_mem_ff[rd_addr];
      end
   end

   `IALT_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(TABLE_DEPTH))
   `IALT_ASSERT(a_count_step, clock, reset, !$past(reset) && (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
   `IALT_ASSERT(a_count_scan_only, clock, reset, !$past(reset) && (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_SCAN))
   `IALT_ASSERT(a_dump_idx_range, clock, reset, (state_ff == ST_DUMP_READ) |-> (CNT_W'(dump_idx_ff) < count_ff))
   `IALT_ASSERT(a_scan_is_learn, clock, reset, (state_ff == ST_SCAN) |-> (cmd_ff.kind == CMD_LEARN))

endmodule

### hdl/ipv4_address_learning_table_core.sv
// IPv4 address learning table core: classifier, command queue and table engine.
// Requests are taken while the two-entry command queue has room.
// A complete IPv4 header runs two lookups, reading one entry a cycle, each inserting
// on a miss while the table has room; other frames are dropped.
// A short or empty dump answers with one header result, else with every entry, newest
// first, each read and then offered. Sync active-high reset empties table and queue.
module ipv4_address_learning_table_core import ialt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ialt_req_if.sink    req_chan,
   ialt_rsp_if.source  rsp_chan
);

   ialt_cmd_if front_cmd ();
   ialt_cmd_if eng_cmd ();

   ialt_front u_front (
      .req (req_chan),
      .cmd (front_cmd)
   );

   ialt_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_cmd),
      .pop   (eng_cmd)
   );

   ialt_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .rsp   (rsp_chan)
   );

endmodule

### dv/tb_top.sv
// Testbench for the IPv4 address learning table core: random frames and dumps, checked result by result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ialt_pkg::*;

   localparam int RANDOM_REQUESTS = 120;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 200;

   class learning_table_scoreboard;
      logic [31:0]     ip_tab[TABLE_DEPTH];
      logic [47:0]     mac_tab[TABLE_DEPTH];
      int              entries;
      int              errors;
      int              checked;
      rsp_payload_type expected_rsps[$];

      function bit ip_known(logic [31:0] ip);
         for (int i = 0; i < entries; i++) begin
            if (ip_tab[i] == ip) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void learn(logic [31:0] ip, logic [47:0] mac);
         if (ip_known(ip) || entries >= TABLE_DEPTH) return;
         for (int i = entries; i > 0; i--) begin
            ip_tab[i]  = ip_tab[i-1];
            mac_tab[i] = mac_tab[i-1];
         end
         ip_tab[0]  = ip;
         mac_tab[0] = mac;
         entries++;
      endfunction

      function logic [31:0] any_known_ip();
         if (entries == 0) return $urandom;
         return ip_tab[$urandom_range(0, entries - 1)];
      endfunction

      function void note_request(req_payload_type r);
         int unsigned     total;
         rsp_payload_type e;
         if (r.operation == OP_OBSERVE) begin
            if (r.header_complete && r.ether_type == ETHERTYPE_IPV4) begin
               learn(r.dst_ip, r.src_mac);
               learn(r.src_ip, r.src_mac);
            end
            return;
         end
         total         = entries * BYTES_PER_ENTRY;
         e.entry_ip    = '0;
         e.entry_mac   = '0;
         e.total_bytes = TOTAL_W'(total);
         e.last        = 1'b1;
         if (r.buffer_bytes < total) begin
            e.status = STATUS_SHORT;
            expected_rsps.push_back(e);
         end else if (entries == 0) begin
            e.status = STATUS_EMPTY;
            expected_rsps.push_back(e);
         end else begin
            for (int i = 0; i < entries; i++) begin
               e.status    = STATUS_ENTRY;
               e.entry_ip  = ip_tab[i];
               e.entry_mac = mac_tab[i];
               e.last      = (i == entries - 1);
               expected_rsps.push_back(e);
            end
         end
      endfunction

      task report(string what);
         $display("mismatch on result %0d: %s", checked, what);
         errors++;
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rsps.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry_ip !== want.entry_ip)
               report($sformatf("entry_ip %h, want %h", got.entry_ip, want.entry_ip));
            if (got.entry_mac !== want.entry_mac)
               report($sformatf("entry_mac %h, want %h", got.entry_mac, want.entry_mac));
            if (got.total_bytes !== want.total_bytes)
               report($sformatf("total_bytes %0d, want %0d", got.total_bytes,
                                want.total_bytes));
            if (got.last !== want.last)
               report($sformatf("last %b, want %b", got.last, want.last));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   results_seen = 0;

   learning_table_scoreboard sb = new();

   ialt_req_if req_if ();
   ialt_rsp_if rsp_if ();

   ipv4_address_learning_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5ns clock = ~clock;

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(op_type op, logic complete, logic [15:0] etype,
                               logic [31:0] dst, logic [31:0] src, logic [47:0] mac,
                               logic [15:0] buf_size, int unsigned gap);
      req_payload_type p;
      p.operation       = op;
      p.header_complete = complete;
      p.ether_type      = etype;
      p.dst_ip          = dst;
      p.src_ip          = src;
      p.src_mac         = mac;
      p.buffer_bytes    = buf_size;
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(p);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ipv4_address_learning_table_core test failed");
         $finish;
      end
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         sb.check_result(rsp_if.payload);
         results_seen <= results_seen + 1;
      end
   end

   // receiver: random stalls, one long hold to back the block up
   initial begin : result_drain
      int unsigned stall_left;
      bit          held;
      stall_left   = 0;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 30) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if ((cycles / 256) % 3 == 0 || $urandom_range(0, 99) < 70) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left = idle_gap();
         end
      end
   end

   initial begin : stimulus
      int unsigned total;
      int unsigned r;
      int unsigned gap;
      logic [31:0] dst;
      logic [31:0] src;
      logic [15:0] etype;
      logic [15:0] buf_size;

      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then frames that must be ignored
      send_request(OP_DUMP, 1'b0, 16'h0000, '0, '0, '0, 16'h0000, idle_gap());
      send_request(OP_DUMP, 1'b1, 16'hffff, '1, '1, '1, 16'hffff, idle_gap());
      send_request(OP_OBSERVE, 1'b0, ETHERTYPE_IPV4, 32'h0a000001, 32'h0a000002,
                   48'h0000_0000_0001, 16'h0000, idle_gap());
      send_request(OP_OBSERVE, 1'b1, 16'h0008, 32'h0a000003, 32'h0a000004,
                   48'h0000_0000_0002, 16'h0000, idle_gap());
      send_request(OP_OBSERVE, 1'b1, 16'hffff, 32'h0a000005, 32'h0a000006,
                   48'h0000_0000_0003, 16'hffff, idle_gap());
      send_request(OP_DUMP, 1'b0, 16'h0000, '0, '0, '0, 16'h0000, idle_gap());
      // learning, equal addresses and already-known addresses
      send_request(OP_OBSERVE, 1'b1, ETHERTYPE_IPV4, 32'h00000000, 32'hffffffff,
                   48'h0000_0000_0000, 16'h0000, idle_gap());
      send_request(OP_OBSERVE, 1'b1, ETHERTYPE_IPV4, 32'hc0a80001, 32'hc0a80001,
                   48'hffff_ffff_ffff, 16'h0000, idle_gap());
      send_request(OP_OBSERVE, 1'b1, ETHERTYPE_IPV4, 32'hffffffff, 32'h55aa33cc,
                   48'h0123_4567_89ab, 16'h0000, idle_gap());
      send_request(OP_OBSERVE, 1'b1, ETHERTYPE_IPV4, 32'hc0a80001, 32'h00000000,
                   48'haaaa_5555_aaaa, 16'h0000, idle_gap());
      // dumps: one short, one exact fit, one with the largest buffer
      send_request(OP_DUMP, 1'b0, 16'h0000, '0, '0, '0, 16'd47, idle_gap());
      send_request(OP_DUMP, 1'b0, 16'h0000, '0, '0, '0, 16'd48, idle_gap());
      send_request(OP_DUMP, 1'b1, 16'hffff, '1, '1, '1, 16'hffff, idle_gap());
      send_request(OP_OBSERVE, 1'b1, ETHERTYPE_IPV4, 32'haa55cc33, 32'h12345678,
                   48'h5555_aaaa_5555, 16'hffff, idle_gap());
      send_request(OP_DUMP, 1'b0, 16'h0000, '0, '0, '0, 16'h0000, idle_gap());

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         gap = (i >= 40 && i < 60) ? 0 : idle_gap();
         if ($urandom_range(0, 99) < 40) begin
            total = sb.entries * BYTES_PER_ENTRY;
            r     = $urandom_range(0, 99);
            if (r < 30)
               buf_size = 16'($urandom_range(0, 65535));
            else if (r < 60)
               buf_size = (total == 0) ? 16'd0 : 16'(total - 1);
            else if (r < 80)
               buf_size = 16'(total);
            else
               buf_size = 16'(total + $urandom_range(1, 12));
            send_request(OP_DUMP, 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
                         $urandom, {16'($urandom), $urandom}, buf_size, gap);
         end else begin
            etype = ($urandom_range(0, 99) < 85) ? ETHERTYPE_IPV4 : 16'($urandom);
            dst   = ($urandom_range(0, 99) < 45) ? sb.any_known_ip() : $urandom;
            src   = ($urandom_range(0, 99) < 45) ? sb.any_known_ip() : $urandom;
            if ($urandom_range(0, 99) < 10) src = dst;
            send_request(OP_OBSERVE, $urandom_range(0, 99) < 85, etype, dst, src,
                         {16'($urandom), $urandom}, 16'($urandom), gap);
         end
      end
      req_if.valid <= 1'b0;

      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ipv4_address_learning_table_core test passed");
      end else begin
         $display("ipv4_address_learning_table_core test failed");
      end
      $finish;
   end

endmodule
